// File: rtl/mcl_pkg.sv
// Shared types, constants and tables for the month calendar layout unit.
`timescale 1ns / 1ps
`default_nettype none

package mcl_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_TODAY_YEAR  = 2'd0;
  localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
  localparam logic [1:0] REG_TODAY_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 14'd0;
  localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   TODAY_DAY_RST   = 5'd1;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // x / 100 == (x * 5243) >> 19 for every 14-bit x.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // x / 7 == (x * 2341) >> 14 for every x below 1024.
  localparam logic [11:0] DIV7_MUL     = 12'd2341;
  localparam int          DIV7_SHIFT   = 14;
  // Multiple of 7 that keeps the weekday sum non-negative.
  localparam logic [9:0]  WEEK_OFFSET  = 10'd329;

  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
  } mcl_in_t;

  typedef struct packed {
    logic [DAY_W-1:0] day_number;
    logic [COL_W-1:0] grid_column;
    logic [ROW_W-1:0] grid_row;
    logic             is_today;
    logic             last_of_month;
  } mcl_out_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } mcl_today_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_MOD,
    ST_EMIT
  } mcl_state_t;

  typedef struct packed {
    logic do_load;
    logic do_div;
    logic do_sum;
    logic do_mod;
    logic do_step;
  } mcl_cmd_t;

  typedef struct packed {
    logic month_ok;
    logic last;
  } mcl_status_t;

  // (13*m - 1) / 5 for the shifted month 1..12 (March is 1).
  function automatic logic [4:0] zel_term(input logic [3:0] m);
    logic [4:0] t;
    case (m)
      4'd1:    t = 5'd2;
      4'd2:    t = 5'd5;
      4'd3:    t = 5'd7;
      4'd4:    t = 5'd10;
      4'd5:    t = 5'd12;
      4'd6:    t = 5'd15;
      4'd7:    t = 5'd18;
      4'd8:    t = 5'd20;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd25;
      4'd11:   t = 5'd28;
      4'd12:   t = 5'd31;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mcl_regs.sv
// APB register file holding the highlighted date.
`timescale 1ns / 1ps
`default_nettype none

module mcl_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mcl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mcl_pkg::DATA_W-1:0] pwdata,
  output      logic [mcl_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  output      mcl_pkg::mcl_today_t        today
);
  import mcl_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      today.year  <= TODAY_YEAR_RST;
      today.month <= TODAY_MONTH_RST;
      today.day   <= TODAY_DAY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TODAY_YEAR:  today.year  <= pwdata[YEAR_W-1:0];
        REG_TODAY_MONTH: today.month <= pwdata[MONTH_W-1:0];
        REG_TODAY_DAY:   today.day   <= pwdata[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TODAY_YEAR:  prdata = DATA_W'(today.year);
      REG_TODAY_MONTH: prdata = DATA_W'(today.month);
      REG_TODAY_DAY:   prdata = DATA_W'(today.day);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mcl_dp.sv
// Datapath: weekday of the first, month length and the day walk.
`timescale 1ns / 1ps
`default_nettype none

module mcl_dp (
  input  wire logic                clk,
  input  wire mcl_pkg::mcl_in_t    item_in,
  input  wire mcl_pkg::mcl_today_t today,
  input  wire mcl_pkg::mcl_cmd_t   cmd,
  output      mcl_pkg::mcl_status_t status,
  output      mcl_pkg::mcl_out_t   result
);
  import mcl_pkg::*;

  logic [YEAR_W-1:0]  yp;        // year shifted for Jan/Feb
  logic               neg;       // shifted year is -1
  logic [MONTH_W-1:0] mp;        // month with March as 1
  logic [MONTH_W-1:0] mon;
  logic [1:0]         y_lo;
  logic               same_month;
  logic [7:0]         cen;
  logic [9:0]         sum;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   day;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;

  logic               in_le2;
  logic [26:0]        cen_prod;
  logic [14:0]        cen_x100;
  logic [14:0]        yoc_w;
  logic [6:0]         yoc;
  logic [9:0]         sum_next;
  logic               leap;
  logic [DAY_W-1:0]   len_next;
  logic [21:0]        q_prod;
  logic [9:0]         rem;

  assign in_le2 = (item_in.month == MON_JAN) || (item_in.month == MON_FEB);
  assign status.month_ok = (item_in.month >= MON_JAN) && (item_in.month <= MON_DEC);
  assign status.last     = (day == len);

  assign cen_prod = 27'(yp) * 27'(DIV100_MUL);
  assign cen_x100 = 15'(cen) * 15'd100;
  assign yoc_w    = 15'(yp) - cen_x100;
  assign yoc      = yoc_w[6:0];

  always_comb begin
    if (neg) begin
      // year of century -1 and century 0: those terms cancel the +1
      sum_next = 10'(zel_term(mp));
      leap     = 1'b1;
    end else begin
      sum_next = 10'(zel_term(mp)) + 10'd1 + 10'(yoc) + 10'(yoc[6:2])
               + 10'(cen[7:2]) + WEEK_OFFSET - 10'({cen, 1'b0});
      // Feb of year y has yp = y-1; y is a century year when yoc is 99
      if (yoc == 7'd99) leap = (cen[1:0] == 2'd3);
      else              leap = (y_lo == 2'd0);
    end
  end

  always_comb begin
    case (mon)
      MON_FEB:                             len_next = leap ? LEN_29 : LEN_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len_next = LEN_30;
      default:                             len_next = LEN_31;
    endcase
  end

  assign q_prod = 22'(sum) * 22'(DIV7_MUL);
  assign rem    = sum - 10'(q_prod[21:DIV7_SHIFT]) * 10'd7;

  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      yp         <= in_le2 ? item_in.year - 14'd1 : item_in.year;
      neg        <= in_le2 && (item_in.year == '0);
      mp         <= in_le2 ? item_in.month + 4'd10 : item_in.month - 4'd2;
      mon        <= item_in.month;
      y_lo       <= item_in.year[1:0];
      same_month <= (item_in.year == today.year) && (item_in.month == today.month);
    end
    if (cmd.do_div) begin
      cen <= cen_prod[26:DIV100_SHIFT];
    end
    if (cmd.do_sum) begin
      sum <= sum_next;
      len <= len_next;
    end
    if (cmd.do_mod) begin
      col <= rem[COL_W-1:0];
      row <= '0;
      day <= 5'd1;
    end else if (cmd.do_step) begin
      day <= day + 5'd1;
      if (col == 3'd6) begin
        col <= '0;
        row <= row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
  end

  assign result.day_number    = day;
  assign result.grid_column   = col;
  assign result.grid_row      = row;
  assign result.is_today      = same_month && (day == today.day);
  assign result.last_of_month = status.last;

endmodule

`default_nettype wire

// File: rtl/mcl_ctrl.sv
// Controller: sequences setup steps and the one-day-per-cycle walk.
`timescale 1ns / 1ps
`default_nettype none

module mcl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire mcl_pkg::mcl_status_t status,
  output      mcl_pkg::mcl_cmd_t    cmd,
  output      logic                 busy,
  output      logic                 strobe
);
  import mcl_pkg::*;

  mcl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.do_load = start;
        // a month outside 1..12 yields nothing
        if (start && status.month_ok) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.do_div = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.do_sum = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.do_mod = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe      = 1'b1;
        cmd.do_step = 1'b1;
        if (status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/month_calendar_layout_unit.sv
// Top level of the month calendar layout unit.
`timescale 1ns / 1ps
`default_nettype none

// A request (year, month) is taken when start is high and busy is low. Setup
// steps follow: century by reciprocal multiply, the weekday sum with month
// length, then the mod-7 reduction. After that one day result appears per
// cycle with strobe high, 28 to 31 of them, the last marked by last_of_month.
// busy stays high after the request until the last result is shown, so a new
// request is taken only once the month is done; a month outside 1..12 gives
// no results and leaves busy low. Results cannot be held off: the receiver
// must take each one in the cycle it is shown. Write the date registers only
// while busy is low.
module month_calendar_layout_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire mcl_pkg::mcl_in_t           item_in,
  output      logic                       strobe,
  output      mcl_pkg::mcl_out_t          result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mcl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mcl_pkg::DATA_W-1:0] pwdata,
  output      logic [mcl_pkg::DATA_W-1:0] prdata,
  output      logic                       pready
);
  import mcl_pkg::*;

  mcl_today_t  today;
  mcl_cmd_t    cmd;
  mcl_status_t status;

  mcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .today   (today)
  );

  mcl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  mcl_dp u_dp (
    .clk     (clk),
    .item_in (item_in),
    .today   (today),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

`default_nettype wire

// File: rtl/mcl_checker.sv
// Port-level checks for the month calendar layout unit, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module mcl_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire mcl_pkg::mcl_in_t  item_in,
  input wire logic              strobe,
  input wire mcl_pkg::mcl_out_t result
);
  import mcl_pkg::*;

  // results only come out while a request is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result shown while idle");

  // a bad month is dropped without going busy
  a_bad_month: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item_in.month == 4'd0 || item_in.month > MON_DEC)) |=> !busy)
    else $error("bad month started a walk");

  // the walk starts on day 1
  a_first_day: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (result.day_number == 5'd1 && result.grid_row == 3'd0))
    else $error("walk did not start on day 1");

  // days follow each other without gaps until the last one
  a_next_day: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_of_month) |=>
      (strobe && result.day_number == $past(result.day_number) + 5'd1))
    else $error("day sequence broken");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_of_month) |=> !strobe)
    else $error("result after last day");

endmodule

bind month_calendar_layout_unit mcl_checker u_mcl_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .item_in (item_in),
  .strobe  (strobe),
  .result  (result)
);

`default_nettype wire

// File: verif/calendar_checker.sv
// Checker for the month calendar layout unit: predicts and compares the day cells.
`timescale 1ns / 1ps

module calendar_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  mcl_pkg::mcl_in_t           item_in,
  input  logic                       strobe,
  input  mcl_pkg::mcl_out_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [mcl_pkg::ADDR_W-1:0] paddr,
  input  logic [mcl_pkg::DATA_W-1:0] pwdata,
  input  logic [mcl_pkg::DATA_W-1:0] prdata,
  output int                         errors,
  output int                         cells_due
);
  import mcl_pkg::*;

  mcl_today_t today;
  mcl_out_t   days_due[$];

  function automatic bit leap(int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int month_days(int y, int m);
    if (m == MON_FEB) return leap(y) ? LEN_29 : LEN_28;
    if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) return LEN_30;
    return LEN_31;
  endfunction

  // Zeller with March as month 1; SV division truncates toward zero, so year -1
  // gives year of century -1 and century 0.
  function automatic int first_weekday_of(int y, int m);
    int yy;
    int mm;
    int yoc;
    int cen;
    int s;
    yy = (m == MON_JAN || m == MON_FEB) ? y - 1 : y;
    mm = (m + 9) % 12 + 1;
    yoc = yy % 100;
    cen = yy / 100;
    s = ((13 * mm - 1) / 5 + 1 + yoc + yoc / 4 + cen / 4 - 2 * cen) % 7;
    if (s < 0) s = (s + 7) % 7;
    return s;
  endfunction

  task automatic lay_out_month(mcl_in_t req);
    int y;
    int m;
    int first;
    int len;
    bit same;
    mcl_out_t entry;
    y = int'(req.year);
    m = int'(req.month);
    if (m < MON_JAN || m > MON_DEC) return;
    first = first_weekday_of(y, m);
    len = month_days(y, m);
    same = (req.year == today.year) && (req.month == today.month);
    for (int d = 1; d <= len; d++) begin
      entry.day_number    = DAY_W'(d);
      entry.grid_column   = COL_W'((first + d - 1) % 7);
      entry.grid_row      = ROW_W'((first + d - 1) / 7);
      entry.is_today      = same && (DAY_W'(d) == today.day);
      entry.last_of_month = (d == len);
      days_due.push_back(entry);
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mcl_out_t want;
    if (rst) begin
      today.year  = TODAY_YEAR_RST;
      today.month = TODAY_MONTH_RST;
      today.day   = TODAY_DAY_RST;
      days_due.delete();
      errors = 0;
    end else begin
      // results of an earlier item go first; a new item cannot have any out yet
      if (strobe) begin
        if (days_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected day cell, got day %0d col %0d row %0d", $time,
                   result.day_number, result.grid_column, result.grid_row);
        end else begin
          want = days_due.pop_front();
          check_field("day_number", want.day_number, result.day_number);
          check_field("grid_column", want.grid_column, result.grid_column);
          check_field("grid_row", want.grid_row, result.grid_row);
          check_field("is_today", want.is_today, result.is_today);
          check_field("last_of_month", want.last_of_month, result.last_of_month);
        end
      end
      if (start && !busy) lay_out_month(item_in);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_TODAY_YEAR:  today.year  = pwdata[YEAR_W-1:0];
            REG_TODAY_MONTH: today.month = pwdata[MONTH_W-1:0];
            REG_TODAY_DAY:   today.day   = pwdata[DAY_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_TODAY_YEAR:  check_field("read today_year", today.year, prdata);
            REG_TODAY_MONTH: check_field("read today_month", today.month, prdata);
            REG_TODAY_DAY:   check_field("read today_day", today.day, prdata);
            default: ;
          endcase
        end
      end
    end
    cells_due = days_due.size();
  end

endmodule

// File: verif/tb_top.sv
// Top of the month calendar layout testbench: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mcl_pkg::*;

  localparam logic [1:0] REG_SPARE     = 2'd3;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  mcl_in_t           item_in;
  logic              strobe;
  mcl_out_t          result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                cells_due;
  int                stall = 0;

  // reset-time date is year 0 January 1, so the first item hits it
  int reset_years[9]  = '{0, 0, 0, 16383, 16383, 0, 9999, 2024, 5};
  int reset_months[9] = '{1, 2, 3, 12, 1, 0, 15, 13, 14};
  int feb_years[5]    = '{2000, 1900, 2023, 2100, 0};

  always #5 clk = ~clk;

  month_calendar_layout_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .strobe(strobe), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  calendar_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .strobe(strobe), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .errors(errors), .cells_due(cells_due)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (psel && penable)) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic request_month(int y, int m);
    @(negedge clk);
    start   <= 1'b1;
    item_in <= '{year: YEAR_W'(y), month: MONTH_W'(m)};
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  function automatic int random_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 40);
    return $urandom_range(41, 90);
  endfunction

  task automatic pause(int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // let every due cell out and settle before touching registers
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (cells_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_access(bit wr, logic [1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // junk above each field checks that only the register's own bits land
  task automatic set_today(int y, int m, int d);
    reg_access(1'b1, REG_TODAY_YEAR, ($urandom() << YEAR_W) | y);
    reg_access(1'b1, REG_TODAY_MONTH, ($urandom() << MONTH_W) | m);
    reg_access(1'b1, REG_TODAY_DAY, ($urandom() << DAY_W) | d);
    reg_access(1'b1, REG_SPARE, $urandom());
    reg_access(1'b0, REG_TODAY_YEAR, '0);
    reg_access(1'b0, REG_TODAY_MONTH, '0);
    reg_access(1'b0, REG_TODAY_DAY, '0);
    reg_access(1'b0, REG_SPARE, '0);
  endtask

  task automatic run_phase(int ty, int tm, int td, bit steady, int count);
    int sent;
    int y;
    int m;
    int r;
    sent = 0;
    set_today(ty, tm, td);
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        y = ty;
        m = (tm >= MON_JAN && tm <= MON_DEC) ? tm : $urandom_range(1, 12);
      end else if (r < 35) begin
        y = $urandom_range(0, 16383);
        m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
      end else begin
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0:       y = $urandom_range(0, 3);
          1:       y = 100 * $urandom_range(0, 99);
          2:       y = $urandom_range(0, 16383);
          default: y = $urandom_range(0, 9999);
        endcase
      end
      request_month(y, m);
      if (m >= MON_JAN && m <= MON_DEC) sent++;
      pause(random_gap(steady));
    end
    settle();
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    item_in = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // year zero Jan/Feb, all-ones year, months outside 1..12
    foreach (reset_years[i]) begin
      request_month(reset_years[i], reset_months[i]);
      pause(random_gap(1'b0));
    end
    settle();

    // every month of a leap year with the leap day highlighted, then century rules
    set_today(2024, 2, 29);
    for (int m = 1; m <= 12; m++) begin
      request_month(2024, m);
      pause(random_gap(1'b0));
    end
    foreach (feb_years[i]) request_month(feb_years[i], MON_FEB);
    settle();

    run_phase(9999, 12, 31, 1'b0, 22);
    run_phase(16383, 15, 31, 1'b1, 22);
    run_phase(0, 1, 1, 1'b0, 22);
    run_phase($urandom_range(0, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
              1'b0, 22);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
